// ===== rtl/adv_mfg_pkg.sv =====
`default_nettype none

package adv_mfg_pkg;

    // Widths of the payload and configuration fields
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned CID_W      = 16;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;

    // Longest payload accepted by default
    localparam int unsigned PAYLOAD_MAX_DEF = 255;

    // Structure type and minimum length of a manufacturer-specific structure
    localparam logic [7:0]       TYPE_MFG    = 8'hFF;
    localparam logic [7:0]       MIN_MFG_LEN = 8'd3;
    localparam logic [CID_W-1:0] CID_RESET   = 16'h02E1;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_MFR_CODE     = 3'd0;
    localparam logic [2:0] REG_DEV_A_ADDR   = 3'd1;
    localparam logic [2:0] REG_DEV_A_ENABLE = 3'd2;
    localparam logic [2:0] REG_DEV_B_ADDR   = 3'd3;
    localparam logic [2:0] REG_DEV_B_ENABLE = 3'd4;

    // Source codes of a result
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_DEV_A = 2'd1;
    localparam logic [1:0] SRC_DEV_B = 2'd2;

    typedef struct packed {
        logic [CID_W-1:0]  mfr_code;
        logic [ADDR_W-1:0] dev_a_addr;
        logic              dev_a_enable;
        logic [ADDR_W-1:0] dev_b_addr;
        logic              dev_b_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0] source;
        logic       found;
        logic [7:0] data_offset;
        logic [7:0] mfg_len;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/adv_mfg_regs.sv =====
`default_nettype none

module adv_mfg_regs (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [adv_mfg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire [adv_mfg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [adv_mfg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output adv_mfg_pkg::t_cfg                  o_cfg
);
    import adv_mfg_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mfr_code     <= CID_RESET;
            r_cfg.dev_a_addr   <= '0;
            r_cfg.dev_a_enable <= 1'b0;
            r_cfg.dev_b_addr   <= '0;
            r_cfg.dev_b_enable <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MFR_CODE:     r_cfg.mfr_code     <= pwdata[CID_W-1:0];
                REG_DEV_A_ADDR:   r_cfg.dev_a_addr   <= pwdata[ADDR_W-1:0];
                REG_DEV_A_ENABLE: r_cfg.dev_a_enable <= pwdata[0];
                REG_DEV_B_ADDR:   r_cfg.dev_b_addr   <= pwdata[ADDR_W-1:0];
                REG_DEV_B_ENABLE: r_cfg.dev_b_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MFR_CODE:     prdata = CFG_DATA_W'(r_cfg.mfr_code);
            REG_DEV_A_ADDR:   prdata = CFG_DATA_W'(r_cfg.dev_a_addr);
            REG_DEV_A_ENABLE: prdata = CFG_DATA_W'(r_cfg.dev_a_enable);
            REG_DEV_B_ADDR:   prdata = CFG_DATA_W'(r_cfg.dev_b_addr);
            REG_DEV_B_ENABLE: prdata = CFG_DATA_W'(r_cfg.dev_b_enable);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/adv_mfg_scan.sv =====
`default_nettype none

module adv_mfg_scan #(
    parameter int unsigned PAYLOAD_MAX = adv_mfg_pkg::PAYLOAD_MAX_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  adv_mfg_pkg::t_cfg              i_cfg,
    input  wire                            i_accept,
    input  wire [7:0]                      i_data_byte,
    input  wire                            i_first_byte,
    input  wire [7:0]                      i_payload_len,
    input  wire [adv_mfg_pkg::ADDR_W-1:0]  i_sender_addr,
    output logic                           o_res_valid,
    output adv_mfg_pkg::t_result           o_res
);
    import adv_mfg_pkg::*;

    localparam logic [7:0] LEN_CAP = 8'(PAYLOAD_MAX);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_CID_LO,
        PH_CID_HI,
        PH_DONE
    } t_phase;

    // Scan state
    t_phase     r_phase,    n_phase;
    logic [7:0] r_byte_pos, n_byte_pos;
    logic [8:0] r_next_hdr, n_next_hdr;
    logic [7:0] r_field_len, n_field_len;
    logic [7:0] r_cid_low,  n_cid_low;
    logic [7:0] r_len_total, n_len_total;
    logic [1:0] r_hit_src,  n_hit_src;
    logic       r_hit_found, n_hit_found;
    logic [7:0] r_hit_off,  n_hit_off;
    logic [7:0] r_hit_len,  n_hit_len;

    // Working copies after the first-byte restart
    t_phase     v_phase;
    logic [7:0] v_pos;
    logic [8:0] v_nh;
    logic [7:0] v_flen;
    logic [7:0] v_cid;
    logic [7:0] v_len;
    logic [1:0] v_src;
    logic       v_found;
    logic [7:0] v_off;
    logic [7:0] v_hlen;
    logic       v_live;
    logic [8:0] v_pos1;
    logic [8:0] v_end;
    logic [8:0] v_len9;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_next_hdr  = r_next_hdr;
        n_field_len = r_field_len;
        n_cid_low   = r_cid_low;
        n_len_total = r_len_total;
        n_hit_src   = r_hit_src;
        n_hit_found = r_hit_found;
        n_hit_off   = r_hit_off;
        n_hit_len   = r_hit_len;
        o_res_valid = 1'b0;

        // Restart on a first byte: latch length, match the sender
        if (i_first_byte) begin
            if (i_payload_len == 8'd0) begin
                v_len = 8'd1;
            end else if (i_payload_len > LEN_CAP) begin
                v_len = LEN_CAP;
            end else begin
                v_len = i_payload_len;
            end
            if (i_cfg.dev_a_enable && (i_sender_addr == i_cfg.dev_a_addr)) begin
                v_src = SRC_DEV_A;
            end else if (i_cfg.dev_b_enable && (i_sender_addr == i_cfg.dev_b_addr)) begin
                v_src = SRC_DEV_B;
            end else begin
                v_src = SRC_NONE;
            end
            v_phase = (v_src == SRC_NONE) ? PH_DONE : PH_HEADER;
            v_pos   = '0;
            v_nh    = '0;
            v_flen  = '0;
            v_cid   = '0;
            v_found = 1'b0;
            v_off   = '0;
            v_hlen  = '0;
            v_live  = i_accept;
        end else begin
            v_len   = r_len_total;
            v_src   = r_hit_src;
            v_phase = r_phase;
            v_pos   = r_byte_pos;
            v_nh    = r_next_hdr;
            v_flen  = r_field_len;
            v_cid   = r_cid_low;
            v_found = r_hit_found;
            v_off   = r_hit_off;
            v_hlen  = r_hit_len;
            // bytes outside a payload are dropped
            v_live  = i_accept && (r_byte_pos < r_len_total);
        end

        v_pos1 = {1'b0, v_pos} + 9'd1;
        v_end  = v_pos1 + {1'b0, i_data_byte};
        v_len9 = {1'b0, v_len};

        // Structure walk
        if (v_phase != PH_DONE) begin
            if ({1'b0, v_pos} == v_nh) begin
                if ((v_pos1 >= v_len9) || (i_data_byte == 8'd0) || (v_end > v_len9)) begin
                    v_phase = PH_DONE;
                end else begin
                    v_flen  = i_data_byte;
                    v_nh    = v_end;
                    v_phase = PH_TYPE;
                end
            end else begin
                unique case (v_phase)
                    PH_TYPE: begin
                        v_phase = ((i_data_byte == TYPE_MFG) && (v_flen >= MIN_MFG_LEN))
                                  ? PH_CID_LO : PH_HEADER;
                    end
                    PH_CID_LO: begin
                        v_cid   = i_data_byte;
                        v_phase = PH_CID_HI;
                    end
                    PH_CID_HI: begin
                        if ({i_data_byte, v_cid} == i_cfg.mfr_code) begin
                            v_found = 1'b1;
                            v_off   = v_pos1[7:0];
                            v_hlen  = v_flen - MIN_MFG_LEN;
                            v_phase = PH_DONE;
                        end else begin
                            v_phase = PH_HEADER;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // Commit on an accepted in-payload beat
        if (v_live) begin
            n_phase     = v_phase;
            n_byte_pos  = v_pos1[7:0];
            n_next_hdr  = v_nh;
            n_field_len = v_flen;
            n_cid_low   = v_cid;
            n_len_total = v_len;
            n_hit_src   = v_src;
            n_hit_found = v_found;
            n_hit_off   = v_off;
            n_hit_len   = v_hlen;
            o_res_valid = (v_pos1 == v_len9);
        end
    end

    assign o_res.source      = v_src;
    assign o_res.found       = v_found;
    assign o_res.data_offset = v_off;
    assign o_res.mfg_len     = v_hlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_byte_pos  <= '0;
            r_next_hdr  <= '0;
            r_field_len <= '0;
            r_cid_low   <= '0;
            r_len_total <= '0;
            r_hit_src   <= SRC_NONE;
            r_hit_found <= 1'b0;
            r_hit_off   <= '0;
            r_hit_len   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_next_hdr  <= n_next_hdr;
            r_field_len <= n_field_len;
            r_cid_low   <= n_cid_low;
            r_len_total <= n_len_total;
            r_hit_src   <= n_hit_src;
            r_hit_found <= n_hit_found;
            r_hit_off   <= n_hit_off;
            r_hit_len   <= n_hit_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adv_mfg_outbuf.sv =====
`default_nettype none

module adv_mfg_outbuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  adv_mfg_pkg::t_result i_res,
    output logic                 o_push_ready,
    output logic                 o_valid,
    input  wire                  i_ready,
    output adv_mfg_pkg::t_result o_res
);
    import adv_mfg_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_take;

    assign out_take     = r_out_valid && i_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_res        = r_out;

    // Output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !out_take) begin
            if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= i_push;
        end
    end

    // Beat data
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !out_take) begin
            if (i_push) begin
                r_skid <= i_res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_push) begin
            r_out <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adv_mfg_data_finder_unit.sv =====
// Manufacturer data finder. Takes one advertising payload byte per beat,
// first_byte set on byte 0 together with the payload length and sender
// address. The sender is compared with the two enabled device addresses
// (device A wins a tie); for a match the length-type structures are walked
// and the first manufacturer-specific one (type 0xFF, length 3 or more)
// carrying the configured company id is reported. One result beat leaves
// for every completed payload, through the registered output buffer.
// Rate: one byte per clock cycle, sustained; each byte is a single update of
// the scan registers. The input stalls only when both the output register
// and its skid entry hold results that the sink has not taken. Registers sit
// at byte address 8*i on the 64-bit configuration port and should be written
// only while no payload is in flight.
`default_nettype none

module adv_mfg_data_finder_unit #(
    parameter int unsigned PAYLOAD_MAX = adv_mfg_pkg::PAYLOAD_MAX_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [adv_mfg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire [adv_mfg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [adv_mfg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    // byte input
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [7:0]                          i_data_byte,
    input  wire                                i_first_byte,
    input  wire [7:0]                          i_payload_len,
    input  wire [adv_mfg_pkg::ADDR_W-1:0]      i_sender_addr,
    // result output
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [1:0]                         o_source,
    output logic                               o_found,
    output logic [7:0]                         o_data_offset,
    output logic [7:0]                         o_mfg_len
);
    import adv_mfg_pkg::*;

    t_cfg    s_cfg;
    t_result s_res;
    t_result s_out;
    logic    s_accept;
    logic    s_res_valid;

    adv_mfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    assign s_accept = i_in_valid && o_in_ready;

    adv_mfg_scan #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (s_cfg),
        .i_accept      (s_accept),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_payload_len (i_payload_len),
        .i_sender_addr (i_sender_addr),
        .o_res_valid   (s_res_valid),
        .o_res         (s_res)
    );

    adv_mfg_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (s_res_valid),
        .i_res        (s_res),
        .o_push_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (s_out)
    );

    assign o_source      = s_out.source;
    assign o_found       = s_out.found;
    assign o_data_offset = s_out.data_offset;
    assign o_mfg_len     = s_out.mfg_len;

`ifndef NO_ASSERTIONS
    // input may only stall behind a pending result
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // a completed payload always reaches the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_res_valid && !o_out_valid) |=> o_out_valid)
        else $error("result lost");

    // no search without a matched device
    a_found_needs_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_source == SRC_DEV_A || o_source == SRC_DEV_B))
        else $error("found without a device match");

    // company id ends at byte 3 at the earliest
    a_offset_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_data_offset >= 8'd4))
        else $error("data offset too small");
`endif

endmodule

`default_nettype wire
